[rtl/pdist_pkg.sv]
// Package for the pairwise squared distance core: payload and command types,
// field widths, operation and register codes, and reset values.
// Depends on nothing; the top level, front end, queue and back end import it.
`timescale 1ns / 1ps
`default_nettype none

package pdist_pkg;

   localparam int IDX_W        = 6;
   localparam int CNT_W        = 5;
   localparam int SAMPLE_WIDTH = 16;
   localparam int DIST_W       = 36;
   localparam int ROWS_W       = 7;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 7;

   localparam int DEFAULT_MAX_ROWS = 64;
   localparam int DEFAULT_MAX_COLS = 16;

   localparam logic [1:0] OP_LOAD_X = 2'd0;
   localparam logic [1:0] OP_LOAD_Y = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMMETRIC = 2'd3;

   localparam logic [ROWS_W-1:0] RESET_ROWS     = 7'd64;
   localparam logic [CNT_W-1:0]  RESET_NUM_COLS = 5'd16;

   typedef struct packed {
      logic [1:0]                     operation;
      logic [IDX_W-1:0]               row_index;
      logic [IDX_W-1:0]               second_index;
      logic signed [SAMPLE_WIDTH-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  pair_row;
      logic [IDX_W-1:0]  pair_col;
      logic [DIST_W-1:0] sq_distance;
      logic              status;
   } rsp_type;

   // For loads row_a and row_b are row and column; for queries they are echoed.
   typedef struct packed {
      logic [1:0]              kind;
      logic [IDX_W-1:0]        row_a;
      logic [IDX_W-1:0]        row_b;
      logic [IDX_W-1:0]        x_row;
      logic [IDX_W-1:0]        y_row;
      logic [CNT_W-1:0]        count;
      logic                    status;
      logic [SAMPLE_WIDTH-1:0] sample;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/pairwise_squared_distance_core.sv]
// Pairwise squared Euclidean distance core, top level.
// Loads two sample matrices element by element and answers pair queries.
// The req_ channel carries load and query transactions; the rsp_ channel
// returns one transaction per query, none for loads or ignored operations.
// The csr_ channel writes the row counts, column count and symmetric mode;
// it is always ready and should only be written while the core is idle.
// A front end decodes each request and range-checks queries, then passes a
// command through a two-entry queue to the back end, which owns both RAMs.
// A load is written into its RAM as the back end takes it. A query reads one
// column pair per cycle through the registered RAM ports and a subtract,
// square and accumulate pipeline, and holds the back end until its result
// enters the response register; a query with an error status, on the
// symmetric diagonal or with no columns skips the reads.
// Requests are accepted while the queue has room, including while a
// response waits; a stalled receiver holds the response register and the
// back end then waits with its next finished query.
// Synchronous reset clears control state and restores register defaults;
// the sample RAMs are not cleared and hold undefined data until loaded.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_squared_distance_core #(
   parameter int MAX_ROWS = pdist_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = pdist_pkg::DEFAULT_MAX_COLS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire pdist_pkg::req_type               req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output pdist_pkg::rsp_type                    rsp_payload,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pdist_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pdist_pkg::CSR_DATA_W-1:0] csr_data
);

   import pdist_pkg::*;

   logic    f_cmd_valid;
   logic    f_cmd_ready;
   cmd_type f_cmd;
   logic    b_cmd_valid;
   logic    b_cmd_ready;
   cmd_type b_cmd;

   pdist_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd_valid   (f_cmd_valid),
      .cmd_ready   (f_cmd_ready),
      .cmd         (f_cmd)
   );

   pdist_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_cmd_valid),
      .push_ready (f_cmd_ready),
      .push_data  (f_cmd),
      .pop_valid  (b_cmd_valid),
      .pop_ready  (b_cmd_ready),
      .pop_data   (b_cmd)
   );

   pdist_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (b_cmd_valid),
      .cmd_ready   (b_cmd_ready),
      .cmd         (b_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[rtl/pdist_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module pdist_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/pdist_front.sv]
// Front end: configuration registers, request decoding, range checks and
// symmetric mirroring; emits one command per useful transaction.
// Depends on pdist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdist_front #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pdist_pkg::req_type                  req_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pdist_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pdist_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                     cmd_valid,
   input  wire logic                                cmd_ready,
   output pdist_pkg::cmd_type                       cmd
);

   import pdist_pkg::*;

   logic [ROWS_W-1:0] rows_x_ff, rows_x_in;
   logic [ROWS_W-1:0] rows_y_ff, rows_y_in;
   logic [CNT_W-1:0]  num_cols_ff, num_cols_in;
   logic              symmetric_ff, symmetric_in;

   logic             load_ok;
   logic             out_of_range;
   logic             useful;
   logic [CNT_W-1:0] eff_cols;
   logic [IDX_W-1:0] r;
   logic [IDX_W-1:0] s;

   assign csr_ready = 1'b1;

   always_comb begin
      rows_x_in    = rows_x_ff;
      rows_y_in    = rows_y_ff;
      num_cols_in  = num_cols_ff;
      symmetric_in = symmetric_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS_X:    rows_x_in    = csr_data[ROWS_W-1:0];
            CSR_ROWS_Y:    rows_y_in    = csr_data[ROWS_W-1:0];
            CSR_NUM_COLS:  num_cols_in  = csr_data[CNT_W-1:0];
            CSR_SYMMETRIC: symmetric_in = csr_data[0];
            default:       rows_x_in    = rows_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_x_ff    <= RESET_ROWS;
         rows_y_ff    <= RESET_ROWS;
         num_cols_ff  <= RESET_NUM_COLS;
         symmetric_ff <= 1'b0;
      end else begin
         rows_x_ff    <= rows_x_in;
         rows_y_ff    <= rows_y_in;
         num_cols_ff  <= num_cols_in;
         symmetric_ff <= symmetric_in;
      end
   end

   assign r = req_payload.row_index;
   assign s = req_payload.second_index;

   assign load_ok = (int'(r) < MAX_ROWS) && (int'(s) < MAX_COLS);
   assign out_of_range = ({1'b0, r} >= rows_x_ff) || ({1'b0, s} >= rows_y_ff)
                         || (int'(r) >= MAX_ROWS) || (int'(s) >= MAX_ROWS);
   assign eff_cols = (int'(num_cols_ff) > MAX_COLS) ? CNT_W'(MAX_COLS) : num_cols_ff;

   always_comb begin
      useful = 1'b0;
      cmd    = '0;
      cmd.kind   = req_payload.operation;
      cmd.row_a  = r;
      cmd.row_b  = s;
      cmd.x_row  = r;
      cmd.y_row  = s;
      cmd.sample = req_payload.sample;
      unique case (req_payload.operation)
         OP_LOAD_X, OP_LOAD_Y: begin
            useful = load_ok;
         end
         OP_QUERY: begin
            useful = 1'b1;
            if (out_of_range) begin
               cmd.status = 1'b1;
            end else if (symmetric_ff && (r == s)) begin
               cmd.count = '0;
            end else begin
               cmd.count = eff_cols;
               if (symmetric_ff && (r > s)) begin
                  cmd.x_row = s;
                  cmd.y_row = r;
               end
            end
         end
         default: begin
            useful = 1'b0;
         end
      endcase
   end

   assign cmd_valid = req_valid && useful;
   assign req_ready = cmd_ready;

endmodule

`default_nettype wire

[rtl/pdist_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on pdist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdist_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire pdist_pkg::cmd_type push_data,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output pdist_pkg::cmd_type      pop_data
);

   import pdist_pkg::*;

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

[rtl/pdist_back.sv]
// Back end: performs loads into the two sample RAMs and runs queries as a
// read, subtract, square and accumulate pipeline; holds the response register.
// Depends on pdist_pkg and pdist_ram.
`timescale 1ns / 1ps
`default_nettype none

module pdist_back #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   input  wire pdist_pkg::cmd_type cmd,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output pdist_pkg::rsp_type      rsp_payload
);

   import pdist_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = 2 * SAMPLE_WIDTH + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              col_ff, col_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [AW-1:0]                 x_base_ff, x_base_in;
   logic [AW-1:0]                 y_base_ff, y_base_in;
   logic                          rv_ff, rv_in;
   logic                          dv_ff, dv_in;
   logic                          sv_ff, sv_in;
   logic signed [SAMPLE_WIDTH:0]  diff_ff, diff_in;
   logic [PW-1:0]                 sq_ff, sq_in;
   logic [DIST_W-1:0]             acc_ff, acc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;
   rsp_type                       pend_ff, pend_in;

   logic                    take;
   logic                    rd_en;
   logic [AW-1:0]           x_rd_addr;
   logic [AW-1:0]           y_rd_addr;
   logic [AW-1:0]           wr_addr;
   logic                    wr_x_en;
   logic                    wr_y_en;
   logic [SAMPLE_WIDTH-1:0] x_rd_data;
   logic [SAMPLE_WIDTH-1:0] y_rd_data;
   logic signed [PW-1:0]    prod;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign take      = cmd_valid && cmd_ready;
   assign wr_addr   = AW'(int'(cmd.row_a) * MAX_COLS + int'(cmd.row_b));
   assign wr_x_en   = take && (cmd.kind == OP_LOAD_X);
   assign wr_y_en   = take && (cmd.kind == OP_LOAD_Y);
   assign rd_en     = (state_ff == ST_RUN) && (col_ff != cnt_ff);
   assign x_rd_addr = x_base_ff + AW'(col_ff);
   assign y_rd_addr = y_base_ff + AW'(col_ff);

   pdist_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(DEPTH)) u_x_ram (
      .clock   (clock),
      .wr_en   (wr_x_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.sample),
      .rd_en   (rd_en),
      .rd_addr (x_rd_addr),
      .rd_data (x_rd_data)
   );

   pdist_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(DEPTH)) u_y_ram (
      .clock   (clock),
      .wr_en   (wr_y_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.sample),
      .rd_en   (rd_en),
      .rd_addr (y_rd_addr),
      .rd_data (y_rd_data)
   );

   assign prod = diff_ff * diff_ff;

   always_comb begin
      rv_in   = rd_en;
      dv_in   = rv_ff;
      sv_in   = dv_ff;
      diff_in = $signed({x_rd_data[SAMPLE_WIDTH-1], x_rd_data})
                - $signed({y_rd_data[SAMPLE_WIDTH-1], y_rd_data});
      sq_in   = $unsigned(prod);
      acc_in  = sv_ff ? acc_ff + DIST_W'(sq_ff) : acc_ff;

      state_in     = state_ff;
      col_in       = rd_en ? col_ff + 1'b1 : col_ff;
      cnt_in       = cnt_ff;
      x_base_in    = x_base_ff;
      y_base_in    = y_base_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (take && (cmd.kind == OP_QUERY)) begin
               acc_in               = '0;
               col_in               = '0;
               cnt_in               = cmd.count;
               x_base_in            = AW'(int'(cmd.x_row) * MAX_COLS);
               y_base_in            = AW'(int'(cmd.y_row) * MAX_COLS);
               pend_in.pair_row     = cmd.row_a;
               pend_in.pair_col     = cmd.row_b;
               pend_in.sq_distance  = '0;
               pend_in.status       = cmd.status;
               state_in = (cmd.count == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (!rd_en && !rv_ff && !dv_ff && !sv_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in             = pend_ff;
               rsp_in.sq_distance = acc_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      sq_ff     <= sq_in;
      acc_ff    <= acc_in;
      col_ff    <= col_in;
      cnt_ff    <= cnt_in;
      x_base_ff <= x_base_in;
      y_base_ff <= y_base_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rv_ff        <= 1'b0;
         dv_ff        <= 1'b0;
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rv_ff        <= rv_in;
         dv_ff        <= dv_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
